### hdl/message_display_scheduler_top_macros.svh
// Assertion macros shared by the checker of the message display scheduler.
`ifndef MESSAGE_DISPLAY_SCHEDULER_TOP_MACROS_SVH
`define MESSAGE_DISPLAY_SCHEDULER_TOP_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define MSCHED_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("message display scheduler check failed");

// The condition must hold in the cycle after the trigger.
`define MSCHED_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("message display scheduler check failed");

`endif

### hdl/msched_pkg.sv
// Package with the widths and time constants of the message display scheduler.
package msched_pkg;

  localparam int unsigned VER_W   = 6;
  localparam int unsigned SEC_W   = 32;
  localparam int unsigned CYC_W   = 11;
  localparam int unsigned MULA_W  = 17;
  localparam int unsigned MULB_W  = 16;

  localparam logic [MULA_W-1:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [MULA_W-1:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [MULA_W-1:0] SEC_PER_MIN  = 17'd60;

endpackage

### hdl/message_display_scheduler_top.sv
// Message display scheduler: one sequencer around a shared multiplier and a remainder unit.
// A message word with the stored version is dropped and the block stays ready. A tick word
// runs the one-bit-per-cycle remainder of the local time by the cycle length, and the
// shared multiplier and a final sum rebuilding the clock when the date or time changed. A
// tick that finds the message finished or not yet started skips the remainder. The result
// word sits in an output register, so the next word is accepted while it waits; a further
// result word then waits in the last step, and the block is not ready, until the receiver
// takes the first one.
module message_display_scheduler_top
  import msched_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [15:0]       clock_date,
  input  logic [7:0]        clock_hour,
  input  logic [7:0]        clock_minute,
  input  logic [VER_W-1:0]  message_version,
  input  logic [15:0]       start_day,
  input  logic [4:0]        start_hour,
  input  logic [5:0]        start_minute,
  input  logic [7:0]        show_seconds,
  input  logic [9:0]        gap_seconds,
  input  logic [5:0]        repeat_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              show,
  output logic [VER_W-1:0]  shown_version
);

  typedef enum logic [3:0] {
    S_IDLE, S_TOT, S_CMP, S_DIV, S_PHASE, S_CLK,
    S_MUL_DAY, S_MUL_HR, S_MUL_MN, S_SUM, S_DONE
  } state_t;

  state_t state;

  logic [SEC_W-1:0] real_seconds;
  logic [SEC_W-1:0] local_seconds;
  logic [SEC_W-1:0] start_seconds;
  logic [15:0]      last_date;
  logic [15:0]      last_clock;
  logic [VER_W-1:0] stored_version;
  logic [7:0]       show_len;
  logic [9:0]       gap_len;
  logic [5:0]       repeats;
  logic             pending_start;
  logic             displaying;

  logic             lat_func;
  logic [15:0]      lat_day;
  logic [7:0]       lat_hr;
  logic [7:0]       lat_mn;

  logic             emit_pend;
  logic             emit_show;
  logic             emit_now;

  logic [SEC_W-1:0] prod;
  logic [SEC_W-1:0] acc;
  logic [SEC_W-1:0] div_sh;
  logic [CYC_W-1:0] rem;
  logic [4:0]       cnt;

  logic [CYC_W-1:0]         cycle_len;
  logic [MULA_W-1:0]        mul_a;
  logic [MULB_W-1:0]        mul_b;
  logic [MULA_W+MULB_W-1:0] mul_full;
  logic [CYC_W:0]           trial;
  logic [SEC_W-1:0]         elapsed;

  assign in_ready  = (state == S_IDLE);
  assign cycle_len = {3'b000, show_len} + {1'b0, gap_len};
  assign trial     = {rem, div_sh[SEC_W-1]};
  assign elapsed   = real_seconds - start_seconds;
  assign mul_full  = mul_a * mul_b;
  assign emit_now  = (state == S_DONE) && emit_pend && (!out_valid || out_ready);

  always_comb begin
    case (state)
      S_TOT: begin
        mul_a = {{(MULA_W-6){1'b0}}, repeats};
        mul_b = {{(MULB_W-CYC_W){1'b0}}, cycle_len};
      end
      S_MUL_DAY: begin
        mul_a = SEC_PER_DAY;
        mul_b = lat_day;
      end
      S_MUL_HR: begin
        mul_a = SEC_PER_HOUR;
        mul_b = {8'h00, lat_hr};
      end
      S_MUL_MN: begin
        mul_a = SEC_PER_MIN;
        mul_b = {8'h00, lat_mn};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      real_seconds   <= '0;
      local_seconds  <= '0;
      start_seconds  <= '0;
      last_date      <= '0;
      last_clock     <= '0;
      stored_version <= '0;
      show_len       <= '0;
      gap_len        <= '0;
      repeats        <= '0;
      pending_start  <= 1'b0;
      displaying     <= 1'b0;
      emit_pend      <= 1'b0;
      emit_show      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid     <= 1'b1;
        show          <= emit_show;
        shown_version <= stored_version;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            lat_func <= func;
            if (func) begin
              lat_day <= start_day;
              lat_hr  <= {3'b000, start_hour};
              lat_mn  <= {2'b00, start_minute};
              if (message_version != stored_version) begin
                stored_version <= message_version;
                show_len       <= show_seconds;
                gap_len        <= gap_seconds;
                repeats        <= repeat_count;
                pending_start  <= 1'b1;
                local_seconds  <= '0;
                if (displaying) begin
                  displaying <= 1'b0;
                  emit_pend  <= 1'b1;
                  emit_show  <= 1'b0;
                end
                state <= S_MUL_DAY;
              end
            end else begin
              lat_day <= clock_date;
              lat_hr  <= clock_hour;
              lat_mn  <= clock_minute;
              state   <= S_TOT;
            end
          end
        end
        S_TOT: begin
          prod  <= mul_full[SEC_W-1:0];
          state <= S_CMP;
        end
        S_CMP: begin
          if (local_seconds >= prod) begin
            if (displaying) begin
              displaying <= 1'b0;
              emit_pend  <= 1'b1;
              emit_show  <= 1'b0;
            end
            state <= S_CLK;
          end else if (pending_start && (real_seconds < start_seconds)) begin
            state <= S_CLK;
          end else begin
            if (pending_start) begin
              local_seconds <= elapsed;
              div_sh        <= elapsed;
              pending_start <= 1'b0;
            end else begin
              div_sh <= local_seconds;
            end
            rem   <= '0;
            cnt   <= 5'd31;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (trial >= {1'b0, cycle_len}) begin
            rem <= CYC_W'(trial - {1'b0, cycle_len});
          end else begin
            rem <= trial[CYC_W-1:0];
          end
          div_sh <= {div_sh[SEC_W-2:0], 1'b0};
          cnt    <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= S_PHASE;
          end
        end
        S_PHASE: begin
          if (rem < {3'b000, show_len}) begin
            if (!displaying) begin
              displaying <= 1'b1;
              emit_pend  <= 1'b1;
              emit_show  <= 1'b1;
            end
          end else if (displaying) begin
            displaying <= 1'b0;
            emit_pend  <= 1'b1;
            emit_show  <= 1'b0;
          end
          local_seconds <= local_seconds + 32'd1;
          state         <= S_CLK;
        end
        S_CLK: begin
          if ((lat_day != last_date) || ({lat_hr, lat_mn} != last_clock)) begin
            last_date  <= lat_day;
            last_clock <= {lat_hr, lat_mn};
            state      <= S_MUL_DAY;
          end else begin
            real_seconds <= real_seconds + 32'd1;
            state        <= S_DONE;
          end
        end
        S_MUL_DAY: begin
          prod  <= mul_full[SEC_W-1:0];
          state <= S_MUL_HR;
        end
        S_MUL_HR: begin
          acc   <= prod;
          prod  <= mul_full[SEC_W-1:0];
          state <= S_MUL_MN;
        end
        S_MUL_MN: begin
          acc   <= acc + prod;
          prod  <= mul_full[SEC_W-1:0];
          state <= S_SUM;
        end
        S_SUM: begin
          if (lat_func) begin
            start_seconds <= acc + prod;
          end else begin
            real_seconds <= acc + prod;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!emit_pend) begin
            state <= S_IDLE;
          end else if (emit_now) begin
            emit_pend <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/msched_checker.sv
// Port checker for the message display scheduler and its bind to the top level.
`include "message_display_scheduler_top_macros.svh"

module msched_port_checker
  import msched_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             func,
  input logic             out_valid,
  input logic             out_ready,
  input logic             show,
  input logic [VER_W-1:0] shown_version
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  // A stalled result word keeps its valid and its payload.
  `MSCHED_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(show) && $stable(shown_version))

  // A tick word always keeps the sequencer busy in the cycle after it is accepted.
  `MSCHED_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && !func, !in_ready)

  // A new result word appears only at the end of an item's work.
  `MSCHED_ASSERT_SAME(a_out_from_work, $rose(out_valid), !$past(in_ready))

endmodule

bind message_display_scheduler_top msched_port_checker u_msched_port_checker (.*);
